>>> hw/rtl/mjdcal_pkg.sv
// ============================================================================
// MJD to calendar date package
// Widths, stream payload layouts and the fixed-point constants used to turn a
// Julian day number into a calendar date and a day fraction into clock time.
// ============================================================================
package mjdcal_pkg;

    localparam int FRAC_BITS_DEF = 32;

    // Stream widths, padded to whole bytes.
    localparam int IN_W  = 64;
    localparam int OUT_W = 64;

    // Input transfer layout, last declared field in the lowest bits.
    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] mjd_frac;
        logic [24:0] mjd_day;
    } t_in_data;

    // Output transfer layout, last declared field in the lowest bits.
    typedef struct packed {
        logic [4:0]  pad;
        logic [21:0] second_q16;
        logic [5:0]  minute_of_hour;
        logic [4:0]  hour_of_day;
        logic [4:0]  cal_day;
        logic [3:0]  cal_month;
        logic [16:0] cal_year;
    } t_out_data;

    // Time of day carried down the pipeline beside the date work.
    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [21:0] second;
    } t_tod;

    // Day number and calendar changeover.
    localparam int unsigned Z_OFFSET   = 2400001;
    localparam int unsigned GREG_START = 2299161;

    // Century correction: floor((4Z - A1_OFS) / A1_DIV) by reciprocal.
    localparam int unsigned A1_OFS   = 7468865;
    localparam int unsigned A1_DIV   = 146097;
    localparam int          A1_SHIFT = 45;
    localparam logic [63:0] A1_MUL64 = ((64'd1 << A1_SHIFT) + 64'(A1_DIV) - 64'd1)
                                       / 64'(A1_DIV);
    localparam logic [27:0] A1_MUL   = A1_MUL64[27:0];

    localparam int unsigned B_OFS = 1524;

    // Year count: floor((100B - C_OFS) / C_DIV) by reciprocal.
    localparam int unsigned C_SCALE = 100;
    localparam int unsigned C_OFS   = 12213;
    localparam int unsigned C_DIV   = 36525;
    localparam int          C_SHIFT = 47;
    localparam logic [63:0] C_MUL64 = ((64'd1 << C_SHIFT) + 64'(C_DIV) - 64'd1)
                                      / 64'(C_DIV);
    localparam logic [31:0] C_MUL   = C_MUL64[31:0];

    localparam int unsigned D_MUL = 1461;

    // Month count: floor(10000 X / 306001) folded into one reciprocal.
    localparam int          E_SHIFT = 28;
    localparam logic [63:0] E_MUL64 = ((64'd1 << E_SHIFT) * 64'd10000 + 64'd306000)
                                      / 64'd306001;
    localparam logic [23:0] E_MUL   = E_MUL64[23:0];
    localparam int unsigned E_WRAP  = 14;

    // floor(30.6001 * e) for every month count e.
    localparam logic [8:0] MONTH_OFS [16] = '{
        9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
        9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
    };

    localparam int unsigned YEAR_OFS_LATE  = 4716;
    localparam int unsigned YEAR_OFS_EARLY = 4715;

    // Clock time scale factors.
    localparam int unsigned HOURS_PER_DAY   = 24;
    localparam int unsigned MINUTES_PER_DAY = 1440;
    localparam int unsigned SECONDS_PER_DAY = 86400;
    localparam int unsigned SIXTY           = 60;

    localparam int NSTG = 9;

endpackage

>>> hw/rtl/mjd_to_calendar_date_top.sv
// ============================================================================
// MJD to calendar date converter
// Converts a Modified Julian Date (whole day plus binary day fraction) into
// year, month, day, hour, minute and Q16 seconds in a nine-stage pipeline.
// ============================================================================
// Throughput: one transfer per cycle while the output side accepts transfers;
// the nine stage registers each take a new item whenever the stage below them
// moves or holds a bubble.
// Reset clears only the stage valid bits; data registers are not reset.
module mjd_to_calendar_date_top #(
    parameter int FRAC_BITS = mjdcal_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // mjd_day[24:0], mjd_frac[56:25], zero pad above
    input  logic [mjdcal_pkg::IN_W-1:0] i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // cal_year[16:0], cal_month[20:17], cal_day[25:21], hour_of_day[30:26],
    // minute_of_hour[36:31], second_q16[58:37], zero pad above
    output logic [mjdcal_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import mjdcal_pkg::*;

    localparam logic [31:0] FRAC_MASK = (FRAC_BITS >= 32) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << FRAC_BITS) - 64'd1);

    t_in_data         in_data;
    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  rdy;

    assign in_data = t_in_data'(i_s_axis_tdata);

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = rdy[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];

    // ---------------- Stage 1: day number, clamped at zero ----------------
    logic [25:0] zs;
    logic [24:0] n_s1_z,  r_s1_z;
    logic [31:0] n_s1_f,  r_s1_f;

    always_comb begin
        zs     = {in_data.mjd_day[24], in_data.mjd_day} + 26'(Z_OFFSET);
        n_s1_z = zs[25] ? '0 : zs[24:0];
        n_s1_f = in_data.mjd_frac & FRAC_MASK;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s1_z <= n_s1_z;
            r_s1_f <= n_s1_f;
        end
    end

    // ------- Stage 2: changeover test, century numerator, time products -------
    logic [36:0] p24;
    logic [42:0] p1440;
    logic [48:0] p86400;
    logic [24:0] r_s2_z;
    logic        n_s2_g,     r_s2_g;
    logic [26:0] n_s2_n1,    r_s2_n1;
    logic [4:0]  n_s2_hours, r_s2_hours;
    logic [10:0] n_s2_mins,  r_s2_mins;
    logic [32:0] n_s2_q16,   r_s2_q16;

    always_comb begin
        n_s2_g     = r_s1_z >= 25'(GREG_START);
        n_s2_n1    = {r_s1_z, 2'b00} - 27'(A1_OFS);
        p24        = 37'(r_s1_f) * 37'(HOURS_PER_DAY);
        p1440      = 43'(r_s1_f) * 43'(MINUTES_PER_DAY);
        p86400     = 49'(r_s1_f) * 49'(SECONDS_PER_DAY);
        n_s2_hours = 5'(p24 >> FRAC_BITS);
        n_s2_mins  = 11'(p1440 >> FRAC_BITS);
        n_s2_q16   = 33'(p86400 >> (FRAC_BITS - 16));
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_s2_z     <= r_s1_z;
            r_s2_g     <= n_s2_g;
            r_s2_n1    <= n_s2_n1;
            r_s2_hours <= n_s2_hours;
            r_s2_mins  <= n_s2_mins;
            r_s2_q16   <= n_s2_q16;
        end
    end

    // ---------- Stage 3: century quotient, minute and second split ----------
    logic [54:0] prod1;
    logic [16:0] m60;
    logic [24:0] r_s3_z;
    logic        r_s3_g;
    logic [8:0]  n_s3_a1,  r_s3_a1;
    t_tod        n_s3_tod, r_s3_tod;

    always_comb begin
        prod1           = 55'(r_s2_n1) * 55'(A1_MUL);
        n_s3_a1         = 9'(prod1 >> A1_SHIFT);
        m60             = 17'(r_s2_mins) * 17'(SIXTY);
        n_s3_tod.hour   = r_s2_hours;
        n_s3_tod.minute = 6'(r_s2_mins - 11'(11'(r_s2_hours) * 11'(SIXTY)));
        n_s3_tod.second = 22'(r_s2_q16 - (33'(m60) << 16));
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_s3_z   <= r_s2_z;
            r_s3_g   <= r_s2_g;
            r_s3_a1  <= n_s3_a1;
            r_s3_tod <= n_s3_tod;
        end
    end

    // ---------------- Stage 4: corrected day count B ----------------
    logic [24:0] n_s4_b, r_s4_b;
    t_tod        r_s4_tod;

    always_comb begin
        if (r_s3_g) begin
            n_s4_b = r_s3_z + 25'(B_OFS + 1) + 25'(r_s3_a1) - 25'(r_s3_a1 >> 2);
        end else begin
            n_s4_b = r_s3_z + 25'(B_OFS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_s4_b   <= n_s4_b;
            r_s4_tod <= r_s3_tod;
        end
    end

    // ---------------- Stage 5: year numerator ----------------
    logic [30:0] n_s5_n2, r_s5_n2;
    logic [24:0] r_s5_b;
    t_tod        r_s5_tod;

    assign n_s5_n2 = 31'(32'(r_s4_b) * 32'(C_SCALE) - 32'(C_OFS));

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_s5_n2  <= n_s5_n2;
            r_s5_b   <= r_s4_b;
            r_s5_tod <= r_s4_tod;
        end
    end

    // ---------------- Stage 6: year count C ----------------
    logic [62:0] prod2;
    logic [15:0] n_s6_c, r_s6_c;
    logic [24:0] r_s6_b;
    t_tod        r_s6_tod;

    always_comb begin
        prod2  = 63'(r_s5_n2) * 63'(C_MUL);
        n_s6_c = 16'(prod2 >> C_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[5]) begin
            r_s6_c   <= n_s6_c;
            r_s6_b   <= r_s5_b;
            r_s6_tod <= r_s5_tod;
        end
    end

    // ---------------- Stage 7: days into the shifted year ----------------
    logic [26:0] d;
    logic [8:0]  n_s7_x, r_s7_x;
    logic [15:0] r_s7_c;
    t_tod        r_s7_tod;

    always_comb begin
        d      = 27'((27'(r_s6_c) * 27'(D_MUL)) >> 2);
        n_s7_x = 9'(r_s6_b - 25'(d));
    end

    always_ff @(posedge i_clk) begin
        if (rdy[6]) begin
            r_s7_x   <= n_s7_x;
            r_s7_c   <= r_s6_c;
            r_s7_tod <= r_s6_tod;
        end
    end

    // ---------------- Stage 8: month count E ----------------
    logic [32:0] prod4;
    logic [3:0]  n_s8_e, r_s8_e;
    logic [8:0]  r_s8_x;
    logic [15:0] r_s8_c;
    t_tod        r_s8_tod;

    always_comb begin
        prod4  = 33'(r_s7_x) * 33'(E_MUL);
        n_s8_e = 4'(prod4 >> E_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (rdy[7]) begin
            r_s8_e   <= n_s8_e;
            r_s8_x   <= r_s7_x;
            r_s8_c   <= r_s7_c;
            r_s8_tod <= r_s7_tod;
        end
    end

    // ---------------- Stage 9: calendar fields, output register ----------------
    logic [3:0]         month;
    logic signed [17:0] yr;
    t_out_data          n_out, r_out;

    always_comb begin
        month = (r_s8_e < 4'(E_WRAP)) ? r_s8_e - 4'd1 : r_s8_e - 4'(E_WRAP - 1);
        if (month > 4'd2) begin
            yr = $signed({2'b00, r_s8_c}) - $signed(18'(YEAR_OFS_LATE));
        end else begin
            yr = $signed({2'b00, r_s8_c}) - $signed(18'(YEAR_OFS_EARLY));
        end
        // There is no year zero: 1 BC comes directly before AD 1.
        if (yr < 18'sd1) begin
            yr = yr - 18'sd1;
        end
        n_out                = '0;
        n_out.cal_year       = 17'(yr);
        n_out.cal_month      = month;
        n_out.cal_day        = 5'(r_s8_x - MONTH_OFS[r_s8_e]);
        n_out.hour_of_day    = r_s8_tod.hour;
        n_out.minute_of_hour = r_s8_tod.minute;
        n_out.second_q16     = r_s8_tod.second;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[8]) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tdata = OUT_W'(r_out);

endmodule
